FILE: src/plt_pkg.sv
// Shared types, constants and fixed-point helpers for the Plucker line pose transform.
package plt_pkg;

  // Number formats: components are Q(W/2).(W/2), rotation entries are Q2.(W-2).
  localparam int COMPONENT_WIDTH = 32;
  localparam int ROT_WIDTH       = 16;
  localparam int COMP_FRAC       = COMPONENT_WIDTH / 2;
  localparam int ROT_FRAC        = ROT_WIDTH - 2;
  localparam int ROW_WIDTH       = 3 * ROT_WIDTH;

  // Configuration port geometry: seven registers at eight-byte spacing.
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int CFG_ADDR_WIDTH  = 6;
  localparam int CFG_IDX_LSB     = 3;

  // Internal arithmetic widths.
  localparam int PROD_WIDTH      = ROT_WIDTH + COMPONENT_WIDTH;
  localparam int DOT_WIDTH       = PROD_WIDTH + 3;
  localparam int DOT_RND_WIDTH   = DOT_WIDTH + 1 - ROT_FRAC;
  localparam int PROD2_WIDTH     = 2 * COMPONENT_WIDTH;
  localparam int CROSS_WIDTH     = PROD2_WIDTH + 1;
  localparam int CROSS_RND_WIDTH = CROSS_WIDTH + 1 - COMP_FRAC;
  localparam int SUM_WIDTH       = (DOT_RND_WIDTH > CROSS_RND_WIDTH ?
                                    DOT_RND_WIDTH : CROSS_RND_WIDTH) + 1;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH     = 4;
  localparam int QUEUE_AW        = $clog2(QUEUE_DEPTH);

  typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
  typedef logic signed [ROT_WIDTH-1:0]       rot_t;
  typedef logic signed [PROD_WIDTH-1:0]      prod_t;
  typedef logic signed [DOT_WIDTH-1:0]       dot_t;
  typedef logic signed [DOT_RND_WIDTH-1:0]   dot_rnd_t;
  typedef logic signed [PROD2_WIDTH-1:0]     prod2_t;
  typedef logic signed [CROSS_WIDTH-1:0]     cross_t;
  typedef logic signed [CROSS_RND_WIDTH-1:0] cross_rnd_t;
  typedef logic signed [SUM_WIDTH-1:0]       sum_t;

  localparam rot_t  ROT_RESET_ENTRY = rot_t'(4096);
  localparam comp_t COMP_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
  localparam comp_t COMP_MIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ROT_ROW0 = 3'd0,
    REG_ROT_ROW1 = 3'd1,
    REG_ROT_ROW2 = 3'd2,
    REG_TRANS_X  = 3'd3,
    REG_TRANS_Y  = 3'd4,
    REG_TRANS_Z  = 3'd5,
    REG_INVERSE  = 3'd6
  } reg_idx_t;

  // Input line: moment then direction.
  typedef struct packed {
    comp_t moment_x;
    comp_t moment_y;
    comp_t moment_z;
    comp_t dir_x;
    comp_t dir_y;
    comp_t dir_z;
  } line_t;

  // Transformed line and saturation flag.
  typedef struct packed {
    comp_t out_moment_x;
    comp_t out_moment_y;
    comp_t out_moment_z;
    comp_t out_dir_x;
    comp_t out_dir_y;
    comp_t out_dir_z;
    logic  overflow;
  } result_t;

  // Pose held in configuration.
  typedef struct packed {
    logic [2:0][ROW_WIDTH-1:0]       rot;
    logic [2:0][COMPONENT_WIDTH-1:0] trans;
    logic                            inv;
  } cfg_t;

  // One queued transaction: the line and the pose direction it was tagged with.
  typedef struct packed {
    line_t line;
    logic  inv;
  } q_entry_t;

  // Handshake from the front part into the queue.
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    comp_t value;
    logic  ovf;
  } sat_t;

  // Round to nearest, ties upward, dropping the rotation fraction bits.
  function automatic dot_rnd_t round_dot(dot_t x);
    logic signed [DOT_WIDTH:0] t;
    t = {x[DOT_WIDTH-1], x};
    t = t + ((DOT_WIDTH+1)'(1) << (ROT_FRAC - 1));
    return t[DOT_WIDTH:ROT_FRAC];
  endfunction

  // Round to nearest, ties upward, dropping the component fraction bits.
  function automatic cross_rnd_t round_cross(cross_t x);
    logic signed [CROSS_WIDTH:0] t;
    t = {x[CROSS_WIDTH-1], x};
    t = t + ((CROSS_WIDTH+1)'(1) << (COMP_FRAC - 1));
    return t[CROSS_WIDTH:COMP_FRAC];
  endfunction

  function automatic sum_t widen_dot(dot_rnd_t x);
    return {{(SUM_WIDTH-DOT_RND_WIDTH){x[DOT_RND_WIDTH-1]}}, x};
  endfunction

  function automatic sum_t widen_cross(cross_rnd_t x);
    return {{(SUM_WIDTH-CROSS_RND_WIDTH){x[CROSS_RND_WIDTH-1]}}, x};
  endfunction

  // Clamp to the component range and report whether the clamp took effect.
  function automatic sat_t saturate(sum_t x);
    sat_t r;
    logic [SUM_WIDTH-COMPONENT_WIDTH:0] hi;
    hi = x[SUM_WIDTH-1:COMPONENT_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      r.value = x[COMPONENT_WIDTH-1:0];
      r.ovf   = 1'b0;
    end else begin
      r.value = x[SUM_WIDTH-1] ? COMP_MIN : COMP_MAX;
      r.ovf   = 1'b1;
    end
    return r;
  endfunction

endpackage

FILE: src/plt_regs.sv
// Configuration register file behind the APB-style port.
module plt_regs
  import plt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output cfg_t                      cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_ADDR_WIDTH-1:CFG_IDX_LSB]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes; the diagonal of the rotation resets to a constant entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rot[0] <= ROW_WIDTH'(ROT_RESET_ENTRY);
      cfg.rot[1] <= ROW_WIDTH'(ROT_RESET_ENTRY) << ROT_WIDTH;
      cfg.rot[2] <= ROW_WIDTH'(ROT_RESET_ENTRY) << (2 * ROT_WIDTH);
      cfg.trans  <= '0;
      cfg.inv    <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_ROT_ROW0: cfg.rot[0]   <= pwdata[ROW_WIDTH-1:0];
        REG_ROT_ROW1: cfg.rot[1]   <= pwdata[ROW_WIDTH-1:0];
        REG_ROT_ROW2: cfg.rot[2]   <= pwdata[ROW_WIDTH-1:0];
        REG_TRANS_X:  cfg.trans[0] <= pwdata[COMPONENT_WIDTH-1:0];
        REG_TRANS_Y:  cfg.trans[1] <= pwdata[COMPONENT_WIDTH-1:0];
        REG_TRANS_Z:  cfg.trans[2] <= pwdata[COMPONENT_WIDTH-1:0];
        REG_INVERSE:  cfg.inv      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back multiplexer.
  always_comb begin
    unique case (idx)
      REG_ROT_ROW0: prdata = CFG_DATA_WIDTH'(cfg.rot[0]);
      REG_ROT_ROW1: prdata = CFG_DATA_WIDTH'(cfg.rot[1]);
      REG_ROT_ROW2: prdata = CFG_DATA_WIDTH'(cfg.rot[2]);
      REG_TRANS_X:  prdata = CFG_DATA_WIDTH'(cfg.trans[0]);
      REG_TRANS_Y:  prdata = CFG_DATA_WIDTH'(cfg.trans[1]);
      REG_TRANS_Z:  prdata = CFG_DATA_WIDTH'(cfg.trans[2]);
      REG_INVERSE:  prdata = CFG_DATA_WIDTH'(cfg.inv);
      default:      prdata = '0;
    endcase
  end

endmodule

FILE: src/plt_front.sv
// Front part: takes input transactions and tags each with the pose direction.
module plt_front
  import plt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  line_t   item,
  input  logic    cfg_inv,
  input  logic    q_full,
  output q_push_t push
);

  logic     held;
  q_entry_t entry;
  logic     accept;
  logic     fire;

  // The holding register frees up whenever the queue has room.
  assign item_stall = held && q_full;
  assign accept     = item_valid && !item_stall;
  assign fire       = held && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= accept || (held && !fire);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry.line <= item;
      entry.inv  <= cfg_inv;
    end
  end

  assign push.valid = held;
  assign push.entry = entry;

endmodule

FILE: src/plt_queue.sv
// Short queue that decouples the front part from the arithmetic back part.
module plt_queue
  import plt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  q_push_t  push,
  output logic     full,
  output logic     head_valid,
  output q_entry_t head,
  input  logic     pop
);

  q_entry_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                push_fire;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign push_fire  = push.valid && !full;
  assign head       = mem[rd_ptr];

  function automatic logic [QUEUE_AW-1:0] bump(logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push_fire && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push.entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push_fire && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push_fire) |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

FILE: src/plt_back.sv
// Back part: five-stage arithmetic pipeline that applies the pose to one line.
module plt_back
  import plt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     head_valid,
  input  q_entry_t head,
  output logic     pop,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result
);

  // Pipeline advance: everything moves unless the output is held.
  logic en;

  // Stage 0 operands.
  rot_t  rot   [3][3];
  rot_t  mat   [3][3];
  comp_t vec_n [3];
  comp_t vec_v [3];
  comp_t trans [3];

  // Stage 1: products.
  logic  s1_valid;
  logic  s1_inv;
  prod_t s1_mv [3][3];
  prod_t s1_mn [3][3];
  prod_t s1_mt [3][3];

  // Stage 2: dot products rounded and clamped.
  sat_t     vsat   [3];
  sat_t     psat   [3];
  dot_rnd_t mdot   [3];
  comp_t    pval   [3];
  logic     ovf2;
  logic     s2_valid;
  comp_t    s2_vo   [3];
  comp_t    s2_p    [3];
  dot_rnd_t s2_mdot [3];
  logic     s2_ovf;

  // Stage 3: cross-product terms.
  logic     s3_valid;
  prod2_t   s3_pa   [3];
  prod2_t   s3_pb   [3];
  comp_t    s3_vo   [3];
  dot_rnd_t s3_mdot [3];
  logic     s3_ovf;

  // Stage 4: rounded cross product.
  cross_rnd_t crnd    [3];
  logic       s4_valid;
  cross_rnd_t s4_c    [3];
  comp_t      s4_vo   [3];
  dot_rnd_t   s4_mdot [3];
  logic       s4_ovf;

  // Stage 5: output register.
  sat_t    msat [3];
  logic    ovf5;
  logic    s5_valid;
  result_t s5_res;

  function automatic int nxt(int i);
    return (i == 2) ? 0 : i + 1;
  endfunction

  function automatic int prv(int i);
    return (i == 0) ? 2 : i - 1;
  endfunction

  assign en           = !(s5_valid && result_stall);
  assign pop          = en && head_valid;
  assign result_valid = s5_valid;
  assign result       = s5_res;

  // Unpack the rotation and pick it or its transpose for this transaction.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        rot[i][j] = cfg.rot[i][j*ROT_WIDTH +: ROT_WIDTH];
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat[i][j] = head.inv ? rot[j][i] : rot[i][j];
      end
    end
    vec_n[0] = head.line.moment_x;
    vec_n[1] = head.line.moment_y;
    vec_n[2] = head.line.moment_z;
    vec_v[0] = head.line.dir_x;
    vec_v[1] = head.line.dir_y;
    vec_v[2] = head.line.dir_z;
    for (int i = 0; i < 3; i++) begin
      trans[i] = cfg.trans[i];
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= head_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  // Stage 1: all rotation-by-component products.
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s1_mv[i][j] <= prod_t'(mat[i][j]) * prod_t'(vec_v[j]);
          s1_mn[i][j] <= prod_t'(mat[i][j]) * prod_t'(vec_n[j]);
          s1_mt[i][j] <= prod_t'(mat[i][j]) * prod_t'(trans[j]);
        end
      end
      s1_inv <= head.inv;
    end
  end

  // Stage 2: sum the products, round, clamp; the inverse translation is negated.
  always_comb begin
    dot_t dv;
    dot_t dn;
    dot_t dt;
    ovf2 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dv = dot_t'(s1_mv[i][0]) + dot_t'(s1_mv[i][1]) + dot_t'(s1_mv[i][2]);
      dn = dot_t'(s1_mn[i][0]) + dot_t'(s1_mn[i][1]) + dot_t'(s1_mn[i][2]);
      dt = dot_t'(s1_mt[i][0]) + dot_t'(s1_mt[i][1]) + dot_t'(s1_mt[i][2]);
      vsat[i] = saturate(widen_dot(round_dot(dv)));
      mdot[i] = round_dot(dn);
      psat[i] = saturate(widen_dot(round_dot(-dt)));
      pval[i] = s1_inv ? psat[i].value : trans[i];
      ovf2    = ovf2 | vsat[i].ovf | (s1_inv & psat[i].ovf);
    end
  end

  always_ff @(posedge clk) begin
    if (en && s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        s2_vo[i]   <= vsat[i].value;
        s2_p[i]    <= pval[i];
        s2_mdot[i] <= mdot[i];
      end
      s2_ovf <= ovf2;
    end
  end

  // Stage 3: the two products of each cross-product component.
  always_ff @(posedge clk) begin
    if (en && s2_valid) begin
      for (int i = 0; i < 3; i++) begin
        s3_pa[i]   <= prod2_t'(s2_p[nxt(i)]) * prod2_t'(s2_vo[prv(i)]);
        s3_pb[i]   <= prod2_t'(s2_p[prv(i)]) * prod2_t'(s2_vo[nxt(i)]);
        s3_vo[i]   <= s2_vo[i];
        s3_mdot[i] <= s2_mdot[i];
      end
      s3_ovf <= s2_ovf;
    end
  end

  // Stage 4: difference of the products, rounded to the component format.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crnd[i] = round_cross(cross_t'(s3_pa[i]) - cross_t'(s3_pb[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en && s3_valid) begin
      for (int i = 0; i < 3; i++) begin
        s4_c[i]    <= crnd[i];
        s4_vo[i]   <= s3_vo[i];
        s4_mdot[i] <= s3_mdot[i];
      end
      s4_ovf <= s3_ovf;
    end
  end

  // Stage 5: add the rotated moment to the cross product and clamp.
  always_comb begin
    ovf5 = s4_ovf;
    for (int i = 0; i < 3; i++) begin
      msat[i] = saturate(widen_dot(s4_mdot[i]) + widen_cross(s4_c[i]));
      ovf5    = ovf5 | msat[i].ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s4_valid) begin
      s5_res.out_moment_x <= msat[0].value;
      s5_res.out_moment_y <= msat[1].value;
      s5_res.out_moment_z <= msat[2].value;
      s5_res.out_dir_x    <= s4_vo[0];
      s5_res.out_dir_y    <= s4_vo[1];
      s5_res.out_dir_z    <= s4_vo[2];
      s5_res.overflow     <= ovf5;
    end
  end

endmodule

FILE: src/plucker_line_pose_transform.sv
// Throughput: one line per cycle while result_stall is low;
// the five-stage multiply pipeline sets it.
// A four-entry queue between the input stage and the pipeline absorbs output stalls.
// Reset (synchronous) empties the pipeline and queue and reloads the pose registers:
// 4096 on the rotation diagonal, zero translation, direct mode.
module plucker_line_pose_transform
  import plt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  line_t                     item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output result_t                   result
);

  cfg_t     cfg;
  q_push_t  push;
  logic     q_full;
  logic     head_valid;
  q_entry_t head;
  logic     pop;

  // Pose registers.
  plt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage.
  plt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .cfg_inv    (cfg.inv),
    .q_full     (q_full),
    .push       (push)
  );

  // Decoupling queue.
  plt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  // Arithmetic pipeline.
  plt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
